// File: design/aeps_pkg.sv
// Shared types and codes for the active/expired priority scheduler.
package aeps_pkg;

   // Operation codes carried in the request beat
   localparam logic [1:0] OP_ADD  = 2'd0;
   localparam logic [1:0] OP_GET  = 2'd1;
   localparam logic [1:0] OP_TEST = 2'd2;

   // Sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   localparam int PID_W = 8;

   // Request beat, last field in the low bits
   typedef struct packed {
      logic [2:0]       static_prio;
      logic signed [2:0] dyn_prio;
      logic [PID_W-1:0] proc_id;
      logic [1:0]       op;
   } req_beat_type;

   // Response beat, last field in the low bits, zero padded to 16 bits
   typedef struct packed {
      logic [2:0]       pad;
      logic             queue_full;
      logic             preempt;
      logic [1:0]       level;
      logic [PID_W-1:0] out_proc_id;
      logic             got_process;
   } rsp_beat_type;

endpackage

// File: design/aeps_ram.sv
// Generic single-write, single-read RAM with registered read data.
module aeps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: design/aeps_ptr_unit.sv
// Shared modulo-depth pointer adder: tail slot on add, head advance on get.
module aeps_ptr_unit #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic [$clog2(QUEUE_DEPTH)-1:0]   base,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0] step,
   output logic [$clog2(QUEUE_DEPTH)-1:0]   next
);

   localparam int HW = $clog2(QUEUE_DEPTH);
   localparam int SW = $clog2(QUEUE_DEPTH + 1) + 1;

   logic [SW-1:0] sum;

   // base < depth and step <= depth, so one conditional subtract wraps it
   assign sum  = SW'(base) + SW'(step);
   assign next = (sum >= SW'(QUEUE_DEPTH)) ? HW'(sum - SW'(QUEUE_DEPTH)) : HW'(sum);

endmodule

// File: design/aeps_prio_enc.sv
// Highest-set-bit encoder over one bank's occupancy bits.
module aeps_prio_enc #(
   parameter int MAX_PRIO = 4
) (
   input  logic [MAX_PRIO-1:0]         occ,
   output logic                        found,
   output logic [$clog2(MAX_PRIO)-1:0] level
);

   localparam int LW = $clog2(MAX_PRIO);

   always_comb begin
      found = 1'b0;
      level = '0;
      for (int i = 0; i < MAX_PRIO; i++) begin
         if (occ[i]) begin
            found = 1'b1;
            level = LW'(i);
         end
      end
   end

endmodule

// File: design/active_expired_priority_scheduler.sv
// Top level of the active/expired priority scheduler.
// Usage:
//  - req channel (req_tvalid/req_tready/req_tdata) takes one operation per beat:
//    add a process, get the next process, or test preemption of a level.
//  - rsp channel returns exactly one beat per request, in request order.
//  - csr channel writes preempt_enable; write it only while the block is idle.
// Timing: a request is taken in the idle state, passes through the execute
// step (queue select, pointer update, queue RAM access) and then the finish
// step (RAM read data lands, response register loads). Ready returns as the
// response register loads, so a new request is taken only once the last one
// has left the finish step; the idle/execute/finish sequence is set by the
// registered queue RAM read.
// A response waiting in the output register does not block the next request;
// only a second finished result waits in the finish step until rsp_tready.
// Reset (synchronous) empties all queues, selects bank 0 as active, clears
// preempt_enable and drops any pending response. Queue RAM is not cleared:
// entries are read only after they have been written.
module active_expired_priority_scheduler
   import aeps_pkg::*;
#(
   parameter int MAX_PRIO    = 4,
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: op[1:0], proc_id[9:2], dyn_prio[12:10], static_prio[15:13]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,
   // rsp_tdata: got_process[0], out_proc_id[8:1], level[10:9], preempt[11],
   //            queue_full[12], zero[15:13]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   // preempt_enable write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);

   localparam int LW         = $clog2(MAX_PRIO);
   localparam int HW         = $clog2(QUEUE_DEPTH);
   localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int WORDS      = 2 * MAX_PRIO * QUEUE_DEPTH;
   localparam int BANK_WORDS = MAX_PRIO * QUEUE_DEPTH;
   localparam int AW         = $clog2(WORDS);

   // ---------------- state ----------------
   logic [1:0]       state_ff, state_in;
   req_beat_type     req_ff, req_in;
   logic [HW-1:0]    head_ff  [2][MAX_PRIO];
   logic [HW-1:0]    head_in  [2][MAX_PRIO];
   logic [CNT_W-1:0] count_ff [2][MAX_PRIO];
   logic [CNT_W-1:0] count_in [2][MAX_PRIO];
   logic [MAX_PRIO-1:0] occ_ff [2];
   logic [MAX_PRIO-1:0] occ_in [2];
   logic             active_ff, active_in;
   logic             pen_ff, pen_in;
   // result of the execute step, held for the finish step
   logic             res_got_ff, res_got_in;
   logic [LW-1:0]    res_lvl_ff, res_lvl_in;
   logic             res_pre_ff, res_pre_in;
   logic             res_full_ff, res_full_in;
   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_beat_type     rsp_data_ff, rsp_data_in;

   // ---------------- execute-step datapath ----------------
   logic             req_fire, exec, load_out;
   logic             is_add, is_get, is_test;
   logic             other_bank, swap, eff_bank;
   logic             expired;
   logic signed [4:0] add_raw;
   logic [LW-1:0]    add_lvl;
   logic             add_bank;
   logic             scan_found;
   logic [LW-1:0]    scan_lvl;
   logic             q_bank;
   logic [LW-1:0]    q_lvl;
   logic [HW-1:0]    cur_head;
   logic [CNT_W-1:0] cur_count;
   logic             is_full;
   logic [CNT_W-1:0] ptr_step;
   logic [HW-1:0]    ptr_next;
   logic [HW-1:0]    slot_sel;
   logic [AW-1:0]    ram_addr;
   logic             ram_we, ram_re;
   logic [PID_W-1:0] ram_rdata;
   logic             lvl_below;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign exec       = (state_ff == ST_EXEC);
   assign load_out   = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_tready);

   assign is_add  = (req_ff.op == OP_ADD);
   assign is_get  = (req_ff.op == OP_GET);
   assign is_test = (req_ff.op == OP_TEST);

   // a get on an empty active bank swaps in the expired bank if it has work
   assign other_bank = ~active_ff;
   assign swap       = is_get && (occ_ff[active_ff] == '0) && (occ_ff[other_bank] != '0);
   assign eff_bank   = active_ff ^ swap;

   aeps_prio_enc #(
      .MAX_PRIO (MAX_PRIO)
   ) u_prio_enc (
      .occ   (occ_ff[eff_bank]),
      .found (scan_found),
      .level (scan_lvl)
   );

   // add target level: expired processes go by static priority, saturated
   assign expired = (req_ff.dyn_prio == -3'sd1);
   assign add_raw = expired ? ($signed({2'b00, req_ff.static_prio}) - 5'sd1)
                            : 5'(req_ff.dyn_prio);
   always_comb begin
      if (add_raw < 5'sd0) begin
         add_lvl = '0;
      end else if (add_raw > 5'(MAX_PRIO - 1)) begin
         add_lvl = LW'(MAX_PRIO - 1);
      end else begin
         add_lvl = LW'(add_raw);
      end
   end
   assign add_bank = expired ? other_bank : active_ff;

   assign q_bank    = is_add ? add_bank : eff_bank;
   assign q_lvl     = is_add ? add_lvl : scan_lvl;
   assign cur_head  = head_ff[q_bank][q_lvl];
   assign cur_count = count_ff[q_bank][q_lvl];
   assign is_full   = (cur_count == CNT_W'(QUEUE_DEPTH));

   // shared pointer adder: head+count for the tail slot, head+1 on a pop
   assign ptr_step = is_add ? cur_count : CNT_W'(1);

   aeps_ptr_unit #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_ptr_unit (
      .base (cur_head),
      .step (ptr_step),
      .next (ptr_next)
   );

   assign slot_sel = is_add ? ptr_next : cur_head;
   assign ram_addr = (q_bank ? AW'(BANK_WORDS) : AW'(0))
                   + AW'(q_lvl) * AW'(QUEUE_DEPTH) + AW'(slot_sel);
   assign ram_we   = exec && is_add && !is_full;
   assign ram_re   = exec && is_get && scan_found;

   aeps_ram #(
      .WIDTH (PID_W),
      .DEPTH (WORDS)
   ) u_queue_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_addr),
      .wdata (req_ff.proc_id),
      .re    (ram_re),
      .raddr (ram_addr),
      .rdata (ram_rdata)
   );

   // signed test: negative dyn_prio is below every occupied level
   localparam int CMP_W = (LW > 2) ? LW : 2;
   assign lvl_below = req_ff.dyn_prio[2] || (CMP_W'(req_ff.dyn_prio[1:0]) < CMP_W'(scan_lvl));

   // ---------------- next state ----------------
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      occ_in       = occ_ff;
      active_in    = active_ff;
      pen_in       = pen_ff;
      res_got_in   = res_got_ff;
      res_lvl_in   = res_lvl_ff;
      res_pre_in   = res_pre_ff;
      res_full_in  = res_full_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid && csr_ready) begin
         pen_in = csr_data;
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               req_in   = req_beat_type'(req_tdata);
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_got_in  = 1'b0;
            res_lvl_in  = '0;
            res_pre_in  = 1'b0;
            res_full_in = 1'b0;
            if (is_add) begin
               res_lvl_in  = add_lvl;
               res_full_in = is_full;
               if (!is_full) begin
                  count_in[q_bank][q_lvl] = cur_count + CNT_W'(1);
                  occ_in[q_bank][q_lvl]   = 1'b1;
               end
            end else if (is_get) begin
               active_in = eff_bank;
               if (scan_found) begin
                  res_got_in = 1'b1;
                  res_lvl_in = scan_lvl;
                  head_in[q_bank][q_lvl]  = ptr_next;
                  count_in[q_bank][q_lvl] = cur_count - CNT_W'(1);
                  if (cur_count == CNT_W'(1)) begin
                     occ_in[q_bank][q_lvl] = 1'b0;
                  end
               end
            end else if (is_test) begin
               res_pre_in = pen_ff && scan_found && lvl_below;
            end
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (load_out) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.pad         = '0;
               rsp_data_in.got_process = res_got_ff;
               rsp_data_in.out_proc_id = res_got_ff ? ram_rdata : '0;
               rsp_data_in.level       = 2'(res_lvl_ff);
               rsp_data_in.preempt     = res_pre_ff;
               rsp_data_in.queue_full  = res_full_ff;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 1'b0;
         pen_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int b = 0; b < 2; b++) begin
            occ_ff[b] <= '0;
            for (int l = 0; l < MAX_PRIO; l++) begin
               head_ff[b][l]  <= '0;
               count_ff[b][l] <= '0;
            end
         end
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         pen_ff       <= pen_in;
         rsp_valid_ff <= rsp_valid_in;
         occ_ff       <= occ_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      res_got_ff  <= res_got_in;
      res_lvl_ff  <= res_lvl_in;
      res_pre_ff  <= res_pre_in;
      res_full_ff <= res_full_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------- checks ----------------
   logic occ_bad;
   logic count_bad;

   always_comb begin
      occ_bad   = 1'b0;
      count_bad = 1'b0;
      for (int b = 0; b < 2; b++) begin
         for (int l = 0; l < MAX_PRIO; l++) begin
            if (occ_ff[b][l] != (count_ff[b][l] != '0)) begin
               occ_bad = 1'b1;
            end
            if (count_ff[b][l] > CNT_W'(QUEUE_DEPTH)) begin
               count_bad = 1'b1;
            end
         end
      end
   end

   a_occ_tracks_count: assert property (@(posedge clock) disable iff (reset) !occ_bad)
      else $error("occupancy bit out of step with queue count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset) !count_bad)
      else $error("queue count above depth");

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_EXEC)
      else $error("accepted request did not enter execute step");

   a_fin_after_exec: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXEC |=> state_ff == ST_FIN)
      else $error("execute step not followed by finish step");

   a_get_pops_occupied: assert property (@(posedge clock) disable iff (reset)
      exec && is_get && (occ_ff[0] != '0 || occ_ff[1] != '0) |-> scan_found)
      else $error("get found nothing while a bank holds work");

endmodule
